/* hw/rtl/rfep_pkg.sv */
// Shared types, constants and decode function for the radar frame event parser.
// No dependencies; every other file of the block imports this package.

package rfep_pkg;

    localparam int unsigned COUNT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
    localparam logic [COUNT_W-1:0] FRAME_BYTES = 4'd10;

    // Byte positions within a frame.
    localparam logic [COUNT_W-1:0] IDX_HDR0    = 4'd0;
    localparam logic [COUNT_W-1:0] IDX_HDR1    = 4'd1;
    localparam logic [COUNT_W-1:0] IDX_TYPE    = 4'd2;
    localparam logic [COUNT_W-1:0] IDX_SUBCMD  = 4'd3;
    localparam logic [COUNT_W-1:0] IDX_DATA    = 4'd6;
    localparam logic [COUNT_W-1:0] IDX_CHKSUM  = 4'd7;
    localparam logic [COUNT_W-1:0] IDX_TAIL0   = 4'd8;
    localparam logic [COUNT_W-1:0] IDX_TAIL1   = 4'd9;

    localparam logic [7:0] HEADER_0 = 8'h53;
    localparam logic [7:0] HEADER_1 = 8'h59;
    localparam logic [7:0] TAIL_0   = 8'h54;
    localparam logic [7:0] TAIL_1   = 8'h43;

    localparam logic [7:0] TYPE_HUMAN   = 8'h80;
    localparam logic [7:0] TYPE_BREATH  = 8'h81;
    localparam logic [7:0] TYPE_SLEEP   = 8'h84;
    localparam logic [7:0] TYPE_HEART   = 8'h85;

    localparam logic [7:0] SUB_01 = 8'h01;
    localparam logic [7:0] SUB_02 = 8'h02;
    localparam logic [7:0] SUB_05 = 8'h05;

    localparam logic [7:0] PRESENCE_ON = 8'h01;

    typedef enum logic [2:0] {
        EV_NONE           = 3'd0,
        EV_PRESENCE       = 3'd1,
        EV_MOTION         = 3'd2,
        EV_RESPIRATION    = 3'd3,
        EV_IN_BED         = 3'd4,
        EV_SLEEP          = 3'd5,
        EV_HEART_RATE     = 3'd6,
        EV_HEART_ABNORMAL = 3'd7
    } t_event_kind;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         sum;
        logic               header_match;
        logic [7:0]         kind_byte;
        logic [7:0]         subcommand_byte;
        logic [7:0]         payload_byte;
        logic [7:0]         sum_byte;
        logic               tail_match;
    } t_frame_state;

    typedef struct packed {
        logic        frame_ok;
        t_event_kind event_kind;
        logic [7:0]  event_value;
    } t_result;

    function automatic t_event_kind decode_kind(input logic [7:0] kind_byte,
                                                input logic [7:0] sub_byte);
        t_event_kind k;
        k = EV_NONE;
        unique case (kind_byte)
            TYPE_HUMAN: begin
                if (sub_byte == SUB_01)      k = EV_PRESENCE;
                else if (sub_byte == SUB_02) k = EV_MOTION;
            end
            TYPE_BREATH: begin
                if (sub_byte == SUB_02)      k = EV_RESPIRATION;
            end
            TYPE_SLEEP: begin
                if (sub_byte == SUB_01)      k = EV_IN_BED;
                else if (sub_byte == SUB_02) k = EV_SLEEP;
            end
            TYPE_HEART: begin
                if (sub_byte == SUB_02)      k = EV_HEART_RATE;
                else if (sub_byte == SUB_05) k = EV_HEART_ABNORMAL;
            end
            default: k = EV_NONE;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/rfep_frame_acc.sv */
// Per-frame byte accumulator: count, checksum, header/tail checks and captured bytes.
// Depends on rfep_pkg.

module rfep_frame_acc
    import rfep_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_frame_state o_next
);

    t_frame_state r_state;
    t_frame_state n_state;

    always_comb begin
        n_state = r_state;
        if (r_state.count < IDX_CHKSUM) begin
            n_state.sum = r_state.sum + i_byte;
        end
        unique case (r_state.count)
            IDX_HDR0:   n_state.header_match = (i_byte == HEADER_0);
            IDX_HDR1:   n_state.header_match = r_state.header_match & (i_byte == HEADER_1);
            IDX_TYPE:   n_state.kind_byte = i_byte;
            IDX_SUBCMD: n_state.subcommand_byte = i_byte;
            IDX_DATA:   n_state.payload_byte = i_byte;
            IDX_CHKSUM: n_state.sum_byte = i_byte;
            IDX_TAIL0:  n_state.tail_match = (i_byte == TAIL_0);
            IDX_TAIL1:  n_state.tail_match = r_state.tail_match & (i_byte == TAIL_1);
            default:    ;
        endcase
        if (r_state.count != COUNT_MAX) begin
            n_state.count = r_state.count + 1'b1;
        end
    end

    assign o_next = n_state;

    // The final byte of a buffer clears everything for the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_state <= '0;
            end else begin
                r_state <= n_state;
            end
        end
    end

endmodule

/* hw/rtl/rfep_decode.sv */
// Frame checks and event decode on the updated frame state.
// Depends on rfep_pkg.

module rfep_decode
    import rfep_pkg::*;
(
    input  t_frame_state i_state,
    output t_result      o_result
);

    logic        ok;
    t_event_kind kind;

    assign ok = (i_state.count >= FRAME_BYTES) && i_state.header_match &&
                i_state.tail_match && (i_state.sum_byte == i_state.sum);

    assign kind = decode_kind(i_state.kind_byte, i_state.subcommand_byte);

    always_comb begin
        o_result.frame_ok    = ok;
        o_result.event_kind  = EV_NONE;
        o_result.event_value = 8'd0;
        if (ok) begin
            o_result.event_kind = kind;
            if (kind == EV_PRESENCE) begin
                o_result.event_value = {7'd0, i_state.payload_byte == PRESENCE_ON};
            end else if (kind != EV_NONE) begin
                o_result.event_value = i_state.payload_byte;
            end
        end
    end

endmodule

/* hw/rtl/rfep_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on rfep_pkg.

module rfep_out_buf
    import rfep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_can_take,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid & i_ready;
    assign o_can_take = ~r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_result   = r_main;

    // A push only arrives while the skid register is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_result;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

endmodule

/* hw/rtl/radar_frame_event_parser_core.sv */
// Top level of the radar frame event parser.
// Depends on rfep_pkg, rfep_frame_acc, rfep_decode and rfep_out_buf.

// The parser takes one byte of a received buffer per clock cycle while input
// ready is high, with a flag on the final byte, and gives one result per buffer:
// a frame-ok flag and the decoded event kind and value. Each byte is folded into
// the frame state by a single add and compare, and on the final byte the checks
// and decode run in the same cycle, so the result is registered into the output
// buffer when that byte is transferred. The result sits in a two-entry output
// buffer, so bytes keep flowing while a result waits; input ready drops only when
// a second finished result is waiting behind an untaken one.

module radar_frame_event_parser_core
    import rfep_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_buffer,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_frame_ok,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_event_value
);

    logic         take;
    logic         can_take;
    t_frame_state next_state;
    t_result      result;
    t_result      out_result;

    assign o_in_ready = can_take;
    assign take       = i_in_valid & can_take;

    rfep_frame_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .i_last  (i_end_of_buffer),
        .o_next  (next_state)
    );

    rfep_decode u_dec (
        .i_state  (next_state),
        .o_result (result)
    );

    rfep_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (take & i_end_of_buffer),
        .i_result   (result),
        .o_can_take (can_take),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_frame_ok    = out_result.frame_ok;
    assign o_event_kind  = out_result.event_kind;
    assign o_event_value = out_result.event_value;

endmodule

/* hw/rtl/rfep_checker.sv */
// Port-level checker for the radar frame event parser, bound to the top level.
// Depends on rfep_pkg and radar_frame_event_parser_core.

module rfep_checker
    import rfep_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_rx_byte,
    input logic       i_end_of_buffer,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_frame_ok,
    input logic [2:0] o_event_kind,
    input logic [7:0] o_event_value
);

    // A result that has not been transferred stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
        $stable(o_frame_ok) && $stable(o_event_kind) && $stable(o_event_value))
        else $error("stalled result changed");

    // A failed frame carries no event.
    a_bad_frame_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_ok |-> o_event_kind == EV_NONE && o_event_value == 8'd0)
        else $error("event reported on a bad frame");

    // Presence is reduced to a single bit.
    a_presence_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == EV_PRESENCE |-> o_event_value[7:1] == 7'd0)
        else $error("presence value wider than one bit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output buffer not empty after reset");

endmodule

bind radar_frame_event_parser_core rfep_checker u_rfep_checker (.*);
